/* hdl/rrkc_pkg.sv */
// shared types and constants for the round-robin key cache
`default_nettype none

package rrkc_pkg;

  localparam int KEY_W   = 32;
  localparam int ADDR_W  = 48;
  localparam int TICK_W  = 63;

  // 2000 ms lifetime at a 10 MHz timer
  localparam logic [TICK_W-1:0] AGE_RESET = TICK_W'(20000000);

  localparam logic ACT_STORE  = 1'b0;
  localparam logic ACT_LOOKUP = 1'b1;

  typedef struct packed {
    logic              action;
    logic [KEY_W-1:0]  process_id;
    logic [ADDR_W-1:0] image_base;
    logic [ADDR_W-1:0] image_size;
    logic [TICK_W-1:0] now;
  } req_t;

  typedef struct packed {
    logic              hit;
    logic [ADDR_W-1:0] found_base;
    logic [ADDR_W-1:0] found_size;
  } rsp_t;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] size;
    logic [TICK_W-1:0] stamp;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t data;
  } cell_t;

endpackage

`default_nettype wire

/* hdl/ttl_round_robin_key_cache_core.sv */
// top level of the round-robin key cache with age expiry
//
//  channel  | signals                       | direction
//  ---------+-------------------------------+----------
//  in       | in_valid, in_stall, in_data   | request beat into the cache
//  out      | out_valid, out_stall, out_data| lookup answer out of the cache
//  cfg      | cfg_we, cfg_wdata             | max age in ticks, write only
//
// a store with nonzero key, base and size writes the slot named by the round-robin pointer
// a lookup registers the beat, rotates the ring once past the compare at cell 0
// and then loads the output register
// reset empties every cell at once and sets max age to 2000 ms at 10 MHz
// a stalled output holds the answer; new beats are taken while it waits, and the
// next lookup answer waits for it to leave
`default_nettype none

module ttl_round_robin_key_cache_core import rrkc_pkg::*; #(
  parameter int ENTRIES = 128
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  req_t              in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output rsp_t              out_data,
  input  logic              cfg_we,
  input  logic [TICK_W-1:0] cfg_wdata
);

  localparam int SLOT_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(ENTRIES - 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]        state;
  logic [SLOT_W-1:0] next_slot;
  logic [SLOT_W-1:0] scan_cnt;
  logic [TICK_W-1:0] max_age;
  logic [KEY_W-1:0]  q_key;
  logic [TICK_W-1:0] q_now;
  logic              found;
  rsp_t              res;

  cell_t ring [ENTRIES];
  cell_t load_data;
  logic  in_beat;
  logic  store_ok;
  logic  shift;
  logic  head_live;
  logic  out_free;
  logic [TICK_W:0] age;

  assign in_stall = (state != S_IDLE);
  assign in_beat  = in_valid && !in_stall;
  assign store_ok = in_beat && (in_data.action == ACT_STORE) &&
                    (in_data.process_id != '0) && (in_data.image_base != '0) &&
                    (in_data.image_size != '0);
  assign shift    = (state == S_SCAN);
  assign out_free = !out_valid || !out_stall;

  assign load_data.valid      = 1'b1;
  assign load_data.data.key   = in_data.process_id;
  assign load_data.data.base  = in_data.image_base;
  assign load_data.data.size  = in_data.image_size;
  assign load_data.data.stamp = in_data.now;

  // cell i takes from cell i+1, so slots pass the head in index order
  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    rrkc_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .shift     (shift),
      .from_next (ring[(i + 1) % ENTRIES]),
      .load      (store_ok && (next_slot == SLOT_W'(i))),
      .load_data (load_data),
      .held      (ring[i])
    );
  end

  // age check at the head; negative age shows up in the top bit
  assign age = {1'b0, q_now} - {1'b0, ring[0].data.stamp};
  assign head_live = ring[0].valid && (ring[0].data.stamp != '0) &&
                     (ring[0].data.key == q_key) && (ring[0].data.base != '0) &&
                     (ring[0].data.size != '0) && !age[TICK_W] &&
                     (age[TICK_W-1:0] <= max_age);

  always_ff @(posedge clk) begin
    if (rst) begin
      max_age <= AGE_RESET;
    end else if (cfg_we) begin
      max_age <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      next_slot <= '0;
      scan_cnt  <= '0;
      found     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (store_ok) begin
        next_slot <= (next_slot == LAST_SLOT) ? '0 : next_slot + 1'b1;
      end
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_beat && (in_data.action == ACT_LOOKUP)) begin
            state    <= S_SCAN;
            scan_cnt <= '0;
            found    <= 1'b0;
          end
        end
        S_SCAN: begin
          if (head_live) begin
            found <= 1'b1;
          end
          scan_cnt <= scan_cnt + 1'b1;
          if (scan_cnt == LAST_SLOT) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      q_key <= in_data.process_id;
      q_now <= in_data.now;
    end
    if (state == S_IDLE) begin
      res <= '0;
    end else if (shift && head_live && !found) begin
      res.hit        <= 1'b1;
      res.found_base <= ring[0].data.base;
      res.found_size <= ring[0].data.size;
    end
    if (state == S_DONE && out_free) begin
      out_data <= res;
    end
  end

  a_lookup_starts_scan: assert property (@(posedge clk) disable iff (rst)
    in_beat && (in_data.action == ACT_LOOKUP) |=> (state == S_SCAN) && (scan_cnt == '0))
    else $error("lookup beat did not start a scan");

  a_store_no_scan: assert property (@(posedge clk) disable iff (rst)
    in_beat && (in_data.action == ACT_STORE) |=> (state == S_IDLE))
    else $error("store beat left idle");

  a_slot_advance: assert property (@(posedge clk) disable iff (rst)
    store_ok |=> (next_slot == (($past(next_slot) == LAST_SLOT) ? '0 :
                                $past(next_slot) + 1'b1)))
    else $error("round-robin pointer did not advance");

  a_scan_ends: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) && (scan_cnt == LAST_SLOT) |=> (state == S_DONE))
    else $error("scan did not end after one full rotation");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.hit |-> (out_data.found_base == '0) && (out_data.found_size == '0))
    else $error("miss answer carries nonzero fields");

endmodule

`default_nettype wire

/* hdl/rrkc_cell.sv */
// one slot of the rotating entry ring
`default_nettype none

module rrkc_cell import rrkc_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  shift,
  input  cell_t from_next,
  input  logic  load,
  input  cell_t load_data,
  output cell_t held
);

  logic   valid;
  entry_t data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      priority if (load) begin
        valid <= load_data.valid;
      end else if (shift) begin
        valid <= from_next.valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    priority if (load) begin
      data <= load_data.data;
    end else if (shift) begin
      data <= from_next.data;
    end
  end

  assign held.valid = valid;
  assign held.data  = data;

endmodule

`default_nettype wire

/* bench/ttl_round_robin_key_cache_check.sv */
// checker for the round-robin key cache: tracks the slots, predicts lookup answers, compares
`default_nettype none

module ttl_round_robin_key_cache_check import rrkc_pkg::*; #(
  parameter int ENTRIES = 128
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_stall,
  input  req_t              in_data,
  input  logic              out_valid,
  input  logic              out_stall,
  input  rsp_t              out_data,
  input  logic              cfg_we,
  input  logic [TICK_W-1:0] cfg_wdata,
  output int                fail_count,
  output int                answers_owed
);

  logic [TICK_W-1:0] age_limit;
  logic [TICK_W-1:0] slot_stamp [ENTRIES];
  logic [KEY_W-1:0]  slot_key   [ENTRIES];
  logic [ADDR_W-1:0] slot_base  [ENTRIES];
  logic [ADDR_W-1:0] slot_size  [ENTRIES];
  int unsigned       write_ptr;
  rsp_t              answers_due [$];
  int                errs = 0;

  // first live slot with this key, scanning up from slot 0
  function automatic rsp_t find_live(input req_t q);
    rsp_t r;
    r = '0;
    if (q.process_id != '0) begin
      for (int s = 0; s < ENTRIES; s++) begin
        if (!r.hit && slot_stamp[s] != '0 && slot_key[s] == q.process_id &&
            slot_base[s] != '0 && slot_size[s] != '0 && q.now >= slot_stamp[s] &&
            (q.now - slot_stamp[s]) <= age_limit) begin
          r.hit        = 1'b1;
          r.found_base = slot_base[s];
          r.found_size = slot_size[s];
        end
      end
    end
    return r;
  endfunction

  task automatic check_answer(input rsp_t got);
    rsp_t want;
    if (answers_due.size() == 0) begin
      $error("unexpected lookup answer: hit %0d base %0h size %0h",
             got.hit, got.found_base, got.found_size);
      errs++;
    end else begin
      want = answers_due.pop_front();
      if (got.hit !== want.hit) begin
        $error("hit: expected %0d, actual %0d", want.hit, got.hit);
        errs++;
      end
      if (got.found_base !== want.found_base) begin
        $error("found_base: expected %0h, actual %0h", want.found_base, got.found_base);
        errs++;
      end
      if (got.found_size !== want.found_size) begin
        $error("found_size: expected %0h, actual %0h", want.found_size, got.found_size);
        errs++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      age_limit = AGE_RESET;
      for (int s = 0; s < ENTRIES; s++) begin
        slot_stamp[s] = '0;
        slot_key[s]   = '0;
        slot_base[s]  = '0;
        slot_size[s]  = '0;
      end
      write_ptr = 0;
      answers_due.delete();
    end else begin
      if (cfg_we) age_limit = cfg_wdata;
      // answers leave before a new lookup beat can be answered
      if (out_valid && !out_stall) check_answer(out_data);
      if (in_valid && !in_stall) begin
        if (in_data.action == ACT_LOOKUP) begin
          answers_due.push_back(find_live(in_data));
        end else if (in_data.process_id != '0 && in_data.image_base != '0 &&
                     in_data.image_size != '0) begin
          slot_key[write_ptr]   = in_data.process_id;
          slot_base[write_ptr]  = in_data.image_base;
          slot_size[write_ptr]  = in_data.image_size;
          slot_stamp[write_ptr] = in_data.now;
          write_ptr = (write_ptr + 1) % ENTRIES;
        end
      end
    end
    fail_count   <= errs;
    answers_owed <= answers_due.size();
  end

endmodule

`default_nettype wire

/* bench/ttl_round_robin_key_cache_core_tb.sv */
// testbench top for the round-robin key cache: drives stores, lookups and max age writes
`default_nettype none

module ttl_round_robin_key_cache_core_tb;
  import rrkc_pkg::*;

  localparam int ENTRIES = 128;
  localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};

  logic              clk = 1'b0;
  logic              rst;
  logic              in_valid;
  logic              in_stall;
  req_t              in_data;
  logic              out_valid;
  logic              out_stall;
  rsp_t              out_data;
  logic              cfg_we;
  logic [TICK_W-1:0] cfg_wdata;
  int                fail_count;
  int                answers_owed;

  int                idle_pct = 0;
  int                stall_left = 0;
  logic [TICK_W-1:0] cur_limit;
  logic [TICK_W-1:0] tick;
  logic [KEY_W-1:0]  key_pool   [8];
  logic [TICK_W-1:0] stamp_pool [8];

  always #4 clk = ~clk;

  ttl_round_robin_key_cache_core #(.ENTRIES(ENTRIES)) dut (
    .clk, .rst, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data,
    .cfg_we, .cfg_wdata
  );

  ttl_round_robin_key_cache_check #(.ENTRIES(ENTRIES)) u_check (
    .clk, .rst, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data,
    .cfg_we, .cfg_wdata, .fail_count, .answers_owed
  );

  // receiver back-pressure in bursts
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      stall_left = $urandom_range(1, 19) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  function automatic logic [ADDR_W-1:0] rand48();
    return ADDR_W'({$urandom, $urandom});
  endfunction

  function automatic logic [TICK_W-1:0] rand63();
    return TICK_W'({$urandom, $urandom});
  endfunction

  // valid stays up from one beat to the next unless a gap is drawn
  task automatic send_beat(input req_t r);
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    in_data  <= r;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic put_store(input logic [KEY_W-1:0] k, input logic [ADDR_W-1:0] b,
                           input logic [ADDR_W-1:0] z, input logic [TICK_W-1:0] t);
    req_t r;
    r.action     = ACT_STORE;
    r.process_id = k;
    r.image_base = b;
    r.image_size = z;
    r.now        = t;
    send_beat(r);
  endtask

  task automatic put_lookup(input logic [KEY_W-1:0] k, input logic [TICK_W-1:0] t);
    req_t r;
    r.action     = ACT_LOOKUP;
    r.process_id = k;
    r.image_base = rand48();
    r.image_size = rand48();
    r.now        = t;
    send_beat(r);
  endtask

  // register writes only once the cache has drained
  task automatic set_age_limit(input logic [TICK_W-1:0] v);
    in_valid <= 1'b0;
    while (answers_owed != 0) @(negedge clk);
    repeat (ENTRIES + 12) @(negedge clk);
    cfg_wdata <= v;
    cfg_we    <= 1'b1;
    @(negedge clk);
    cfg_we    <= 1'b0;
    cur_limit = v;
  endtask

  task automatic random_phase(input int n_items);
    int                done;
    int                i;
    int unsigned       span;
    logic [KEY_W-1:0]  k;
    logic [ADDR_W-1:0] b;
    logic [ADDR_W-1:0] z;
    logic [TICK_W-1:0] t;
    done = 0;
    span = (cur_limit > 1000000) ? 1000000 : int'(cur_limit) + 1;
    while (done < n_items) begin
      case ($urandom_range(0, 9))
        0, 1, 2: ;
        3, 4, 5: tick = tick + $urandom_range(1, 8);
        6, 7, 8: tick = tick + $urandom_range(0, span);
        default: tick = rand63() >> $urandom_range(0, 40);
      endcase
      i = $urandom_range(0, 7);
      if ($urandom_range(0, 99) < 45) begin
        if ($urandom_range(0, 3) == 0) key_pool[i] = $urandom;
        k = key_pool[i];
        b = ($urandom_range(0, 19) == 0) ? '1 : rand48();
        z = ($urandom_range(0, 19) == 0) ? '1 : rand48();
        t = ($urandom_range(0, 32) == 0) ? '0 : tick;
        // broken stores: one of the required fields zero
        case ($urandom_range(0, 39))
          0:       k = '0;
          1:       b = '0;
          2:       z = '0;
          default: ;
        endcase
        put_store(k, b, z, t);
        if (k != '0 && b != '0 && z != '0) begin
          stamp_pool[i] = t;
          done++;
        end
      end else begin
        case ($urandom_range(0, 32))
          0:       k = '0;
          1, 2:    k = $urandom;
          default: k = key_pool[i];
        endcase
        case ($urandom_range(0, 9))
          0, 1, 2, 3: t = tick;
          4:          t = stamp_pool[i] + cur_limit;
          5:          t = stamp_pool[i] + cur_limit + 1;
          6:          t = stamp_pool[i] - 1;
          7, 8:       t = tick + $urandom_range(0, span);
          default:    t = rand63();
        endcase
        put_lookup(k, t);
        done++;
      end
    end
  endtask

  initial begin
    logic [TICK_W-1:0] limits [8];
    int                pcts   [4];
    rst       = 1'b1;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    cur_limit = AGE_RESET;
    tick      = TICK_W'(1000);
    for (int j = 0; j < 8; j++) begin
      key_pool[j]   = $urandom;
      stamp_pool[j] = '0;
    end
    limits = '{'0, TICK_MAX, TICK_W'(1), TICK_W'(5000),
               TICK_W'($urandom_range(2, 200000)), AGE_RESET, rand63(), TICK_W'(3000)};
    pcts   = '{0, 10, 30, 60};
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed beats at the reset max age
    put_lookup('0, '0);
    put_lookup(32'h1234, TICK_W'(50));
    put_store('1, '1, '1, TICK_W'(100));
    put_lookup('1, TICK_W'(100));
    put_lookup('1, TICK_W'(100) + AGE_RESET);
    put_lookup('1, TICK_W'(101) + AGE_RESET);
    put_lookup('1, TICK_W'(99));
    put_store('0, ADDR_W'(5), ADDR_W'(5), TICK_W'(200));
    put_store(32'd5, '0, ADDR_W'(5), TICK_W'(200));
    put_store(32'd5, ADDR_W'(5), '0, TICK_W'(200));
    put_lookup(32'd5, TICK_W'(200));
    put_store(32'd1, ADDR_W'(1), ADDR_W'(1), '0);
    put_lookup(32'd1, TICK_W'(5));
    put_store(32'd2, ADDR_W'('h123), ADDR_W'('h456), TICK_MAX);
    put_lookup(32'd2, TICK_MAX);
    // same key twice: the lower slot answers
    put_store(32'd7, ADDR_W'('hA), ADDR_W'('hB), TICK_W'(300));
    put_store(32'd7, ADDR_W'('hC), ADDR_W'('hD), TICK_W'(300));
    put_lookup(32'd7, TICK_W'(301));
    put_lookup('0, TICK_W'(300));

    for (int ph = 0; ph < 8; ph++) begin
      idle_pct = 0;
      set_age_limit(limits[ph]);
      idle_pct = (ph == 7) ? 0 : pcts[$urandom_range(0, 3)];
      random_phase(200);
    end

    in_valid <= 1'b0;
    idle_pct = 0;
    while (answers_owed != 0) @(negedge clk);
    repeat (ENTRIES + 12) @(negedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("tb: failure");
    $finish;
  end

endmodule

`default_nettype wire

/* ttl_round_robin_key_cache_core.f */
hdl/rrkc_pkg.sv
hdl/rrkc_cell.sv
hdl/ttl_round_robin_key_cache_core.sv
bench/ttl_round_robin_key_cache_check.sv
bench/ttl_round_robin_key_cache_core_tb.sv
